FILE: src/sira_pkg.sv
// Package of the signed integer to ASCII radix unit.
// Holds widths, character codes, the state type and the digit helpers.
// Depends on nothing; every other file of the block imports it.
package sira_pkg;

  // Width of the signed input value.
  localparam int unsigned VALUE_BITS = 32;
  // Counter width that can hold VALUE_BITS itself.
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned CHAR_W     = 7;
  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned S_DATA_W   = ((VALUE_BITS + RADIX_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W   = ((CHAR_W + 7) / 8) * 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
  localparam logic [DIGIT_W-1:0] DEC_BASE     = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS   = 7'h2D;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // Status from the serial divider to the sequencer.
  typedef struct packed {
    logic done;     // one-cycle pulse: quotient and remainder are final
    logic quot_nz;  // the final quotient is not zero
  } div_stat_t;

  // Clamp a radix into the range 2..36.
  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // ASCII code of one digit value 0..35.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_BASE) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_UPPER_A + CHAR_W'(d - DEC_BASE);
    end
    return res;
  endfunction

endpackage

FILE: src/sira_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Divides a VALUE_BITS magnitude by a radix of up to six bits.
// Depends on sira_pkg.
module sira_serial_div
  import sira_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [DIGIT_W-1:0]    rem_o,
  output div_stat_t             stat_o
);

  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    dvsr_q, dvsr_d;
  logic [CNT_W-1:0]      step_q, step_d;
  logic                  done_q, done_d;
  logic                  nz_q, nz_d;
  logic [DIGIT_W:0]      trial;
  logic [DIGIT_W:0]      diff;
  logic                  qbit;

  // One restoring step: shift the next dividend bit into the remainder.
  always_comb begin
    trial = {rem_q, quot_q[VALUE_BITS-1]};
    diff  = trial - {1'b0, dvsr_q};
    qbit  = (trial >= {1'b0, dvsr_q});
  end

  // Load on start, then step until the counter runs out.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    step_d = step_q;
    nz_d   = nz_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
      step_d = CNT_W'(VALUE_BITS);
      nz_d   = 1'b0;
    end else if (step_q != '0) begin
      quot_d = {quot_q[VALUE_BITS-2:0], qbit};
      rem_d  = qbit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      step_d = step_q - CNT_W'(1);
      nz_d   = nz_q | qbit;
      done_d = (step_q == CNT_W'(1));
    end
  end

  // Control state under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
      nz_q   <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
      nz_q   <= nz_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign quot_o         = quot_q;
  assign rem_o          = rem_q;
  assign stat_o.done    = done_q;
  assign stat_o.quot_nz = nz_q;

endmodule

FILE: src/sira_digit_stack.sv
// Last-in first-out digit store built as a shift line.
// Push shifts toward the deep end, pop shifts back toward the head.
// Depends on sira_pkg.
module sira_digit_stack
  import sira_pkg::*;
(
  input  logic               clk_i,
  input  logic               push_i,
  input  logic               pop_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [DIGIT_W-1:0] head_o
);

  logic [DIGIT_W-1:0] ent_q [VALUE_BITS];
  logic [DIGIT_W-1:0] ent_d [VALUE_BITS];

  // Push and pop shift the entries; entry 0 takes a pushed digit.
  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      ent_d[i] = ent_q[i];
      if (push_i) begin
        ent_d[i] = (i == 0) ? digit_i : ent_q[(i == 0) ? 0 : i - 1];
      end else if (pop_i) begin
        ent_d[i] = (i == VALUE_BITS - 1) ? ent_q[i]
                                          : ent_q[(i == VALUE_BITS - 1) ? i : i + 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign head_o = ent_q[0];

endmodule

FILE: src/signed_integer_to_ascii_radix_unit.sv
// Top level of the signed integer to ASCII radix unit.
// Instantiates sira_serial_div and sira_digit_stack; depends on sira_pkg.
//
// Usage:
//   The slave stream takes one signed value and a radix per transaction
//   (tdata: value in bits 31:0, radix in bits 37:32). The master stream gives
//   the text one ASCII character per transaction, most significant first,
//   with a leading '-' for negative values; tlast marks the final character.
//   Radix values outside 2..36 are clamped into that range.
// Timing:
//   Each digit costs one serial division (one quotient bit per cycle in the
//   divider) and the push of its remainder. The first character is offered
//   once the last remainder is pushed, then one character per cycle while the
//   receiver takes them. At most 32 digits are produced, plus a minus sign.
//   The block takes one item at a time; tready rises again once the final
//   character is loaded into the output register.
// Reset and stalls:
//   Reset empties the output register and returns to idle. When the receiver
//   stalls, the output register holds its character and the emission waits.
module signed_integer_to_ascii_radix_unit
  import sira_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,   // value, radix, zero fill
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,   // character, zero fill
  output logic                m_axis_tlast_o
);

  state_e                state_q, state_d;
  logic                  neg_q, neg_d;
  logic [RADIX_W-1:0]    radix_q, radix_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  mvalid_q, mvalid_d;
  logic [CHAR_W-1:0]     mchar_q, mchar_d;
  logic                  mlast_q, mlast_d;

  logic                  in_acc;
  logic [VALUE_BITS-1:0] in_val;
  logic [RADIX_W-1:0]    in_radix;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  out_free;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0]    div_divisor;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  div_stat_t             div_stat;
  logic                  stk_push;
  logic                  stk_pop;
  logic [DIGIT_W-1:0]    stk_head;

  // Unpack the input and form the magnitude.
  assign in_val   = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_radix = sat_radix(s_axis_tdata_i[VALUE_BITS +: RADIX_W]);
  assign in_mag   = in_val[VALUE_BITS-1] ? (~in_val + VALUE_BITS'(1)) : in_val;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !mvalid_q || m_axis_tready_i;

  // Sequencer: divide repeatedly, then emit sign and digits.
  always_comb begin
    state_d      = state_q;
    neg_d        = neg_q;
    radix_d      = radix_q;
    cnt_d        = cnt_q;
    mvalid_d     = mvalid_q && !m_axis_tready_i;
    mchar_d      = mchar_q;
    mlast_d      = mlast_q;
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_divisor  = radix_q;
    stk_push     = 1'b0;
    stk_pop      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          div_start    = 1'b1;
          div_dividend = in_mag;
          div_divisor  = in_radix;
          radix_d      = in_radix;
          neg_d        = in_val[VALUE_BITS-1];
          cnt_d        = '0;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          stk_push = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
          if (div_stat.quot_nz) begin
            div_start = 1'b1;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          if (neg_q) begin
            mchar_d = CHAR_MINUS;
            mlast_d = 1'b0;
            neg_d   = 1'b0;
          end else begin
            mchar_d = digit_char(stk_head);
            mlast_d = (cnt_q == CNT_W'(1));
            stk_pop = 1'b1;
            cnt_d   = cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mvalid_q <= 1'b0;
      neg_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
      neg_q    <= neg_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
    mchar_q <= mchar_d;
    mlast_q <= mlast_d;
  end

  sira_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  sira_digit_stack u_stack (
    .clk_i   (clk_i),
    .push_i  (stk_push),
    .pop_i   (stk_pop),
    .digit_i (div_rem),
    .head_o  (stk_head)
  );

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = M_DATA_W'(mchar_q);
  assign m_axis_tlast_o  = mlast_q;

endmodule

FILE: src/sira_checker.sv
// Port-level checker of the signed integer to ASCII radix unit, with its bind.
// Sees the top level's ports only; depends on sira_pkg.
module sira_checker
  import sira_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [M_DATA_W-1:0] m_axis_tdata_o,   // character, zero fill
  input logic                m_axis_tlast_o
);

  // A stalled character holds its value and its last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output transaction changed");

  // The block is busy in the cycle after it takes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a conversion was running");

  // While ready for a new item, only a final character may still wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("ready for input with an unfinished text pending");

  // A minus sign is never the final character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[CHAR_W-1:0] == CHAR_MINUS) |-> !m_axis_tlast_o)
    else $error("minus sign marked as final character");

endmodule

bind signed_integer_to_ascii_radix_unit sira_checker u_sira_checker (.*);
